[rtl/sci_pkg.sv]
// ----------------------------------------------------------------------------
// sci_pkg: shared types and constants for the sorted coordinate index
// Table size, derived widths, the stored entry layout, the cell control
// struct and the sequencer states.
// ----------------------------------------------------------------------------
package sci_pkg;

    // table depth
    localparam int MAX_ENTRIES = 256;

    // widths fixed by the interface fields
    localparam int COORD_W   = 16;
    localparam int KEY_W     = 2 * COORD_W;
    localparam int POS_W     = 32;
    localparam int RI_W      = 8;
    localparam int COUNT_O_W = 9;

    // widths derived from the depth
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = CNT_W + RI_W;

    // read gather: cells are OR-combined in groups, one register per group
    localparam int GROUP      = 16;
    localparam int NUM_GROUPS = (MAX_ENTRIES + GROUP - 1) / GROUP;

    // sign flip so an unsigned compare gives signed (X, Y) order
    localparam logic [COORD_W-1:0] SIGN_FLIP = {1'b1, {(COORD_W - 1){1'b0}}};

    // one stored entry: biased key over file offset
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } sci_entry_t;

    // insert control broadcast to every cell
    typedef struct packed {
        logic       ins_en;
        sci_entry_t entry;
    } sci_ins_t;

    // read request broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [CMP_W-1:0] idx;
    } sci_rd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } sci_state_t;

endpackage

[rtl/sorted_coordinate_index.sv]
// ----------------------------------------------------------------------------
// sorted_coordinate_index: table of grid entries kept sorted by (X, Y)
// Inserts shift later entries up through a row of cells; reads return the
// entry at a sorted position. Every item gives one result with the count.
//
//   channel  direction  tdata fields (low bit up)                  tuser
//   s_*      in         map_x, map_y, file_pos, read_index         op
//   m_*      out        entry_count, out_x, out_y, out_pos         out_valid, dropped
//
// Each item goes through accept, a step for the cell row to shift or
// select (with the first gather level registered) and a step to load the
// result register; a new item is taken only after that load, back in idle.
// The result register lets the next item be accepted while a result waits;
// the sequencer stalls in its last step only while that register is full.
// Reset clears the count and control; table entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_coordinate_index
    import sci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // map_x[15:0], map_y[31:16], file_pos[63:32], read_index[71:64]
    input  logic        s_tuser,   // op
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // entry_count[8:0], out_x[24:9], out_y[40:25], out_pos[72:41], zero fill
    output logic [1:0]  m_tuser    // out_valid[0], dropped[1]
);

    sci_state_t state_reg;
    sci_state_t state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // item held during work
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [POS_W-1:0] pos_reg;
    logic [RI_W-1:0]  idx_reg;

    logic hit_reg;
    logic hit_next;
    logic drop_reg;
    logic drop_next;

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [79:0] m_tdata_reg;
    logic [79:0] m_tdata_next;
    logic [1:0]  m_tuser_reg;
    logic [1:0]  m_tuser_next;

    logic       accept;
    logic       full;
    logic       hit;
    logic       load_out;
    sci_ins_t   ctrl;
    sci_rd_t    rd;
    sci_entry_t rd_data;

    assign accept = s_tvalid && s_tready;
    assign full   = count_reg == CNT_W'(MAX_ENTRIES);
    assign hit    = CMP_W'(idx_reg) < CMP_W'(count_reg);

    // cell row control; the read select stays on through the result step
    // so the gathered entry survives an output stall
    assign ctrl.ins_en    = (state_reg == ST_EXEC) && !op_reg && !full;
    assign ctrl.entry.key = key_reg;
    assign ctrl.entry.pos = pos_reg;
    assign rd.en          = ((state_reg == ST_EXEC) || (state_reg == ST_EMIT)) && op_reg && hit;
    assign rd.idx         = CMP_W'(idx_reg);

    sci_chain u_chain (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd      (rd),
        .count   (count_reg),
        .rd_data (rd_data)
    );

    // capture the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tuser;
            key_reg <= {s_tdata[15:0] ^ SIGN_FLIP, s_tdata[31:16] ^ SIGN_FLIP};
            pos_reg <= s_tdata[63:32];
            idx_reg <= s_tdata[71:64];
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        hit_next      = hit_reg;
        drop_next     = drop_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        load_out      = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                hit_next   = op_reg && hit;
                drop_next  = !op_reg && full;
                if (ctrl.ins_en)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // result register load; gathered data is zero unless a read hit
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0,
                             rd_data.pos,
                             rd_data.key[COORD_W-1:0] ^ (hit_reg ? SIGN_FLIP : '0),
                             rd_data.key[KEY_W-1:COORD_W] ^ (hit_reg ? SIGN_FLIP : '0),
                             COUNT_O_W'(count_reg)};
            m_tuser_next  = {drop_reg, hit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        drop_reg    <= drop_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/sci_cell.sv]
// ----------------------------------------------------------------------------
// sci_cell: one slot of the sorted table
// Holds one entry. On an insert it either keeps its entry, takes the entry
// of the cell below (shift up) or takes the new entry.
// ----------------------------------------------------------------------------
module sci_cell
    import sci_pkg::*;
(
    input  logic       clk,
    input  sci_ins_t   ctrl,
    input  sci_entry_t prev_entry,
    input  logic       prev_ins,
    input  logic       occupied,
    input  logic       rd_sel,
    output sci_entry_t entry,
    output logic       ins,
    output sci_entry_t sel_data
);

    sci_entry_t entry_reg;
    sci_entry_t entry_next;

    // insertion point is here or below: empty slot or strictly greater key
    assign ins = !occupied || (entry_reg.key > ctrl.entry.key);

    // shift, place or hold
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            priority if (prev_ins)
            begin
                entry_next = prev_entry;
            end
            else if (ins)
            begin
                entry_next = ctrl.entry;
            end
            else
            begin
                entry_next = entry_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign sel_data = rd_sel ? entry_reg : '0;

endmodule

[rtl/sci_chain.sv]
// ----------------------------------------------------------------------------
// sci_chain: row of table cells with a registered read gather
// Cells pass entries upward on insert. A read selects one cell, whose
// masked entry is OR-combined per group into registers, then across groups.
// ----------------------------------------------------------------------------
module sci_chain
    import sci_pkg::*;
(
    input  logic             clk,
    input  sci_ins_t         ctrl,
    input  sci_rd_t          rd,
    input  logic [CNT_W-1:0] count,
    output sci_entry_t       rd_data
);

    sci_entry_t entry_w    [MAX_ENTRIES];
    sci_entry_t prev_w     [MAX_ENTRIES];
    sci_entry_t sel_w      [MAX_ENTRIES];
    logic       ins_w      [MAX_ENTRIES];
    logic       prev_ins_w [MAX_ENTRIES];

    sci_entry_t group_or_reg  [NUM_GROUPS];
    sci_entry_t group_or_next [NUM_GROUPS];

    // cell row
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic occupied;
        logic rd_sel;

        if (i == 0)
        begin : g_first
            assign prev_w[i]     = '0;
            assign prev_ins_w[i] = 1'b0;
        end
        else
        begin : g_link
            assign prev_w[i]     = entry_w[i-1];
            assign prev_ins_w[i] = ins_w[i-1];
        end

        assign occupied = CNT_W'(i) < count;
        assign rd_sel   = rd.en && (rd.idx == CMP_W'(i));

        sci_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .prev_entry (prev_w[i]),
            .prev_ins   (prev_ins_w[i]),
            .occupied   (occupied),
            .rd_sel     (rd_sel),
            .entry      (entry_w[i]),
            .ins        (ins_w[i]),
            .sel_data   (sel_w[i])
        );
    end

    // first gather level: OR within each group
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_or_next[g] = '0;
            for (int m = 0; m < GROUP; m++)
            begin
                if (g * GROUP + m < MAX_ENTRIES)
                begin
                    group_or_next[g] = group_or_next[g] | sel_w[g * GROUP + m];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_or_reg[g] <= group_or_next[g];
        end
    end

    // second gather level: OR across group registers
    always_comb
    begin
        rd_data = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            rd_data = rd_data | group_or_reg[g];
        end
    end

endmodule

[rtl/sci_checker.sv]
// ----------------------------------------------------------------------------
// sci_checker: port-level checks for the sorted coordinate index
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module sci_checker
    import sci_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item in work");

    // a read hit and a dropped insert never appear together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("valid and dropped both set");

    // data fields are zero unless a read hit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[79:9] == '0)
        else $error("nonzero data without valid");

    // a dropped insert only happens on a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[8:0] == COUNT_O_W'(MAX_ENTRIES))
        else $error("drop reported below full count");

endmodule

bind sorted_coordinate_index sci_checker u_sci_checker (.*);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_coordinate_index
// A queue-fed driver pushes insert and read items into the slave stream. A
// monitor keeps a shadow copy of the sorted (X, Y) table and predicts the
// result of each accepted item. It then checks every result on the master
// stream, field by field, in order. Random idling on both sides and a full
// drain after the first phase exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;
    import sci_pkg::*;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } coord_op_t;

    // one input item
    typedef struct packed {
        coord_op_t                  op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [POS_W-1:0]           pos;
        logic [RI_W-1:0]            idx;
    } coord_item_t;

    // one result item
    typedef struct packed {
        logic [COUNT_O_W-1:0]       count;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [POS_W-1:0]           pos;
        logic                       valid;
        logic                       dropped;
    } index_result_t;

    localparam int ITEMS_PER_PHASE = 610;
    localparam int TAIL_CYCLES     = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;     // map_x, map_y, file_pos, read_index
    logic        s_tuser = 1'b0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;          // entry_count, out_x, out_y, out_pos, zero fill
    logic [1:0]  m_tuser;          // out_valid, dropped

    // items waiting to be driven, results waiting to arrive
    coord_item_t   coord_items_q[$];
    index_result_t index_results_q[$];

    // shadow of the sorted table
    logic signed [COORD_W-1:0] grid_x[MAX_ENTRIES];
    logic signed [COORD_W-1:0] grid_y[MAX_ENTRIES];
    logic [POS_W-1:0]          grid_pos[MAX_ENTRIES];
    int                        grid_count = 0;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   mismatch_count = 0;
    logic s_taken = 1'b0;

    sorted_coordinate_index i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // apply one item to the shadow table and return its result
    function automatic index_result_t index_update(coord_item_t it);
        index_result_t r;
        int            slot;
        int            k;
        r = '0;
        if (it.op == OP_INSERT)
        begin
            if (grid_count >= MAX_ENTRIES)
            begin
                r.dropped = 1'b1;
            end
            else
            begin
                // first stored entry with a strictly greater key; equal keys stay in order
                slot = 0;
                while (slot < grid_count &&
                       !(grid_x[slot] > it.x || (grid_x[slot] == it.x && grid_y[slot] > it.y)))
                    slot++;
                for (k = grid_count; k > slot; k--)
                begin
                    grid_x[k]   = grid_x[k-1];
                    grid_y[k]   = grid_y[k-1];
                    grid_pos[k] = grid_pos[k-1];
                end
                grid_x[slot]   = it.x;
                grid_y[slot]   = it.y;
                grid_pos[slot] = it.pos;
                grid_count++;
            end
        end
        else if (it.idx < grid_count)
        begin
            r.x     = grid_x[it.idx];
            r.y     = grid_y[it.idx];
            r.pos   = grid_pos[it.idx];
            r.valid = 1'b1;
        end
        r.count = COUNT_O_W'(grid_count);
        return r;
    endfunction

    // coordinate mix: a tight cluster for equal keys, the extremes, or anything
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int sel;
        logic signed [COORD_W-1:0] v;
        sel = $urandom_range(99);
        if (sel < 40)
            v = COORD_W'(int'($urandom_range(4)) - 2);
        else if (sel < 55)
        begin
            case ($urandom_range(4))
                0: v = 16'sh8000;
                1: v = 16'sh7fff;
                2: v = -16'sd1;
                3: v = 16'sd1;
                default: v = 16'sd0;
            endcase
        end
        else
            v = COORD_W'($urandom);
        return v;
    endfunction

    task automatic queue_item(coord_op_t op, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, logic [POS_W-1:0] pos,
                              logic [RI_W-1:0] idx);
        coord_item_t it;
        it.op  = op;
        it.x   = x;
        it.y   = y;
        it.pos = pos;
        it.idx = idx;
        coord_items_q.push_back(it);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        coord_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || s_taken)
            begin
                if (coord_items_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    it = coord_items_q.pop_front();
                    s_tdata  <= {it.idx, it.pos, it.y, it.x};
                    s_tuser  <= it.op;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        coord_item_t   it;
        index_result_t want;
        index_result_t got;
        s_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                it.op  = coord_op_t'(s_tuser);
                it.x   = s_tdata[15:0];
                it.y   = s_tdata[31:16];
                it.pos = s_tdata[63:32];
                it.idx = s_tdata[71:64];
                index_results_q.push_back(index_update(it));
            end
            if (m_tvalid && m_tready)
            begin
                got.count   = m_tdata[8:0];
                got.x       = m_tdata[24:9];
                got.y       = m_tdata[40:25];
                got.pos     = m_tdata[72:41];
                got.valid   = m_tuser[0];
                got.dropped = m_tuser[1];
                if (index_results_q.size() == 0)
                begin
                    $error("unexpected result: entry_count %0d", got.count);
                    mismatch_count++;
                end
                else
                begin
                    want = index_results_q.pop_front();
                    if (got.count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count, got.count);
                        mismatch_count++;
                    end
                    if (got.x !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.x, got.x);
                        mismatch_count++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.y, got.y);
                        mismatch_count++;
                    end
                    if (got.pos !== want.pos)
                    begin
                        $error("out_pos: expected %0h, got %0h", want.pos, got.pos);
                        mismatch_count++;
                    end
                    if (got.valid !== want.valid)
                    begin
                        $error("out_valid: expected %0b, got %0b", want.valid, got.valid);
                        mismatch_count++;
                    end
                    if (got.dropped !== want.dropped)
                    begin
                        $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int planned;
        int ph;
        int n;
        coord_op_t op;
        logic [RI_W-1:0] idx;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reads on an empty table, extreme keys, equal keys, sorted readback
        queue_item(OP_READ, 16'sd0, 16'sd0, 32'h0, 8'd0);
        queue_item(OP_READ, 16'sh7fff, -16'sd1, 32'hffff_ffff, 8'd255);
        queue_item(OP_INSERT, 16'sh7fff, 16'sh7fff, 32'hffff_ffff, 8'hff);
        queue_item(OP_INSERT, 16'sh8000, 16'sh8000, 32'h0000_0000, 8'h00);
        queue_item(OP_INSERT, 16'sd0, 16'sd0, 32'h0000_0001, 8'h00);
        queue_item(OP_INSERT, -16'sd1, -16'sd1, 32'h8000_0000, 8'h00);
        queue_item(OP_INSERT, 16'sd0, 16'sd0, 32'h0000_0002, 8'h00);
        queue_item(OP_INSERT, 16'sh8000, 16'sh7fff, 32'h5555_aaaa, 8'h00);
        queue_item(OP_INSERT, 16'sh7fff, 16'sh8000, 32'haaaa_5555, 8'h00);
        queue_item(OP_INSERT, 16'sd0, -16'sd1, 32'h1234_5678, 8'h00);
        queue_item(OP_INSERT, 16'sd0, 16'sd0, 32'h0000_0003, 8'h00);
        for (n = 0; n < 9; n++)
            queue_item(OP_READ, 16'sd0, 16'sd0, 32'h0, RI_W'(n));
        queue_item(OP_READ, 16'sd0, 16'sd0, 32'h0, 8'd9);
        queue_item(OP_READ, 16'sd0, 16'sd0, 32'h0, 8'd255);
        planned = 9;

        // random phases: the table fills, then inserts are refused
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 18; recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                op = ($urandom_range(99) < 30) ? OP_INSERT : OP_READ;
                if (planned > 0 && $urandom_range(99) < 70)
                    idx = RI_W'($urandom_range(((planned > 256) ? 256 : planned) - 1));
                else
                    idx = RI_W'($urandom_range(255));
                queue_item(op, pick_coord(), pick_coord(), $urandom, idx);
                if (op == OP_INSERT && planned < MAX_ENTRIES)
                    planned++;
            end
            while (coord_items_q.size() > 0)
                @(posedge clk);
            // hold off the sender until the block has fully drained once
            if (ph == 0)
            begin
                while (s_tvalid || index_results_q.size() > 0)
                    @(posedge clk);
            end
        end

        while (coord_items_q.size() > 0 || s_tvalid)
            @(posedge clk);
        while (index_results_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
